### rtl/paced_packet_slot_shaper_unit_macros.svh
// Assertion macros for the checker file of the slot shaper.
`ifndef PACED_PACKET_SLOT_SHAPER_UNIT_MACROS_SVH
`define PACED_PACKET_SLOT_SHAPER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPSS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot shaper check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot shaper check failed");

`endif

### rtl/ppss_pkg.sv
// Package with the sizes, codes, types and rate table of the slot shaper.
`default_nettype none
package ppss_pkg;

    localparam int SLOTS       = 32;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int HANDLE_W    = 16;
    localparam int SLOT_OUT_W  = 5;
    localparam int IDX_X_W     = (IDX_W > SLOT_OUT_W) ? IDX_W : SLOT_OUT_W;
    localparam int BUDGET_W    = 7;
    localparam int PERIOD_W    = 10;
    localparam int ALT_W       = 32;
    localparam int MODE_W      = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = MODE_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACING_ENABLE = 1'd1;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef enum logic [1:0] {
        EV_STORED  = 2'd0,
        EV_DROPPED = 2'd1,
        EV_SENT    = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        JOB_STORE = 2'd0,
        JOB_DRAIN = 2'd1,
        JOB_FLUSH = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind           kind;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    budget;
    } t_job;

    typedef enum logic [1:0] {
        CNT_KEEP  = 2'd0,
        CNT_CLEAR = 2'd1,
        CNT_INC   = 2'd2,
        CNT_ONE   = 2'd3
    } t_cnt_op;

    typedef struct packed {
        logic [BUDGET_W-1:0] budget;
        logic [PERIOD_W-1:0] period;
        t_cnt_op             cnt_op;
    } t_mode_res;

    // Packets per period, next period and the alternation counter update for a mode.
    function automatic t_mode_res ppss_mode(input logic [MODE_W-1:0] mode,
                                            input logic [ALT_W-1:0]  cnt);
        t_mode_res           r;
        logic                alt;
        logic [3:0]          m;
        logic [BUDGET_W-1:0] hi;
        logic [BUDGET_W-1:0] lo;
        r.budget = '0;
        r.period = PERIOD_W'(1);
        r.cnt_op = CNT_KEEP;
        alt = 1'b0;
        m   = 4'd0;
        hi  = '0;
        lo  = '0;
        case (mode)
            5'd0:  r.budget = 7'd106;
            5'd1:  r.budget = 7'd34;
            5'd2:  r.budget = 7'd17;
            5'd3:  begin alt = 1'b1; m = 4'd1; hi = 7'd9;  lo = 7'd8;  end
            5'd4:  begin alt = 1'b1; m = 4'd4; hi = 7'd5;  lo = 7'd4;  end
            5'd5:  begin alt = 1'b1; m = 4'd9; hi = 7'd3;  lo = 7'd2;  end
            5'd6:  r.budget = 7'd1;
            5'd7:  begin r.budget = 7'd1; r.period = 10'd2; end
            5'd8:  begin
                if (cnt == 32'd1) begin
                    r.budget = 7'd11;
                    r.cnt_op = CNT_CLEAR;
                end else begin
                    r.budget = 7'd10;
                    r.cnt_op = CNT_ONE;
                end
            end
            5'd9:  begin alt = 1'b1; m = 4'd2; hi = 7'd6;  lo = 7'd5;  end
            5'd10: begin alt = 1'b1; m = 4'd2; hi = 7'd2;  lo = 7'd3;  end
            5'd11: begin alt = 1'b1; m = 4'd2; hi = 7'd2;  lo = 7'd1;  end
            5'd12: begin alt = 1'b1; m = 4'd2; hi = 7'd2;  lo = 7'd1;  r.period = 10'd2; end
            5'd13: begin r.budget = 7'd1; r.period = 10'd3; end
            5'd14: begin r.budget = 7'd1; r.period = 10'd6; end
            5'd15: begin alt = 1'b1; m = 4'd1; hi = 7'd13; lo = 7'd12; end
            5'd16: begin alt = 1'b1; m = 4'd1; hi = 7'd2;  lo = 7'd1;  r.period = 10'd3; end
            5'd17: r.budget = 7'd4;
            5'd18: begin alt = 1'b1; m = 4'd1; hi = 7'd2;  lo = 7'd1;  end
            5'd19: r.budget = 7'd13;
            5'd21: begin r.budget = 7'd1; r.period = 10'd1000; end
            default: r.budget = '0;
        endcase
        if (alt) begin
            if (cnt == ALT_W'(m)) begin
                r.budget = hi;
                r.cnt_op = CNT_CLEAR;
            end else begin
                r.budget = lo;
                r.cnt_op = CNT_INC;
            end
        end
        return r;
    endfunction

    // A period never sends more than the ring holds.
    function automatic logic [CNT_W-1:0] ppss_cap_budget(input logic [BUDGET_W-1:0] budget);
        if (32'(budget) > SLOTS) begin
            return CNT_W'(SLOTS);
        end
        return CNT_W'(budget);
    endfunction

    function automatic logic [IDX_W-1:0] ppss_next_idx(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(SLOTS - 1)) begin
            return '0;
        end
        return idx + IDX_W'(1);
    endfunction

    function automatic logic [SLOT_OUT_W-1:0] ppss_slot_out(input logic [IDX_W-1:0] idx);
        logic [IDX_X_W-1:0] wide;
        wide = IDX_X_W'(idx);
        return wide[SLOT_OUT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/ppss_cmd_if.sv
// Input channel of the slot shaper: command and packet handle.
`default_nettype none
interface ppss_cmd_if;
    import ppss_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [HANDLE_W-1:0] packet_handle;

    modport source (output valid, output command, output packet_handle, input ready);
    modport sink   (input valid, input command, input packet_handle, output ready);
endinterface
`default_nettype wire

### rtl/ppss_res_if.sv
// Result channel of the slot shaper: event, handle, slot and last flag.
`default_nettype none
interface ppss_res_if;
    import ppss_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            event_res;
    logic [HANDLE_W-1:0]   handle_out;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  last;

    modport source (output valid, output event_res, output handle_out, output slot_index,
                    output last, input ready);
    modport sink   (input valid, input event_res, input handle_out, input slot_index,
                    input last, output ready);
endinterface
`default_nettype wire

### rtl/ppss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ppss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### rtl/ppss_front.sv
// Front end: accepts items, holds configuration, paces ticks and issues jobs.
`default_nettype none
module ppss_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ppss_cmd_if.sink                        i_cmd,
    input  logic                            i_q_full,
    output logic                            o_push,
    output ppss_pkg::t_job                  o_job
);
    import ppss_pkg::*;

    logic [MODE_W-1:0]   r_rate_mode;
    logic                r_pacing;
    logic [PERIOD_W-1:0] r_ticks_left;
    logic [PERIOD_W-1:0] n_ticks_left;
    logic [ALT_W-1:0]    r_alt_cnt;
    logic [ALT_W-1:0]    n_alt_cnt;
    logic                accept;
    t_mode_res           mres;

    assign i_cmd.ready = !i_q_full;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign mres        = ppss_mode(r_rate_mode, r_alt_cnt);

    always_comb begin
        n_ticks_left = r_ticks_left;
        n_alt_cnt    = r_alt_cnt;
        o_push       = 1'b0;
        o_job.kind   = JOB_STORE;
        o_job.handle = i_cmd.packet_handle;
        o_job.budget = '0;
        if (accept) begin
            if (i_cmd.command == CMD_ENQUEUE) begin
                o_push = 1'b1;
                if (r_pacing) begin
                    o_job.kind = JOB_STORE;
                end else begin
                    o_job.kind   = JOB_FLUSH;
                    o_job.budget = CNT_W'(SLOTS);
                end
            end else if (r_pacing) begin
                if (r_ticks_left > PERIOD_W'(1)) begin
                    n_ticks_left = r_ticks_left - PERIOD_W'(1);
                end else begin
                    // Period expired: reload and release this period's budget.
                    n_ticks_left = mres.period;
                    case (mres.cnt_op)
                        CNT_KEEP:  n_alt_cnt = r_alt_cnt;
                        CNT_CLEAR: n_alt_cnt = '0;
                        CNT_INC:   n_alt_cnt = r_alt_cnt + ALT_W'(1);
                        CNT_ONE:   n_alt_cnt = ALT_W'(1);
                        default:   n_alt_cnt = r_alt_cnt;
                    endcase
                    if (mres.budget != '0) begin
                        o_push       = 1'b1;
                        o_job.kind   = JOB_DRAIN;
                        o_job.budget = ppss_cap_budget(mres.budget);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mode  <= '0;
            r_pacing     <= 1'b1;
            r_ticks_left <= PERIOD_W'(1);
            r_alt_cnt    <= '0;
        end else begin
            r_ticks_left <= n_ticks_left;
            r_alt_cnt    <= n_alt_cnt;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RATE_MODE:     r_rate_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_PACING_ENABLE: r_pacing    <= i_cfg_data[0];
                    default:           r_pacing    <= r_pacing;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

### rtl/ppss_queue.sv
// Short job queue between the front end and the slot engine.
`default_nettype none
module ppss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppss_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ppss_pkg::t_job o_head
);
    import ppss_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end
endmodule
`default_nettype wire

### rtl/ppss_back.sv
// Slot engine: owns the slot ring and carries out store, drain and flush jobs.
`default_nettype none
module ppss_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ppss_pkg::t_job i_q_job,
    output logic           o_q_pop,
    ppss_res_if.source     o_res
);
    import ppss_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STORE = 5'b00010,
        S_READ  = 5'b00100,
        S_OUT   = 5'b01000,
        S_PASS  = 5'b10000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    t_job                  r_job;
    t_job                  n_job;
    logic [SLOTS-1:0]      r_valid;
    logic [SLOTS-1:0]      n_valid;
    logic [IDX_W-1:0]      r_send;
    logic [IDX_W-1:0]      n_send;
    logic [IDX_W-1:0]      r_store;
    logic [IDX_W-1:0]      n_store;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [IDX_W-1:0]      r_rd_slot;
    logic [IDX_W-1:0]      n_rd_slot;
    logic                  r_rd_last;
    logic                  n_rd_last;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_event                r_out_ev;
    t_event                n_out_ev;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic [HANDLE_W-1:0]   n_out_handle;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic [SLOT_OUT_W-1:0] n_out_slot;
    logic                  r_out_last;
    logic                  n_out_last;
    logic                  out_free;
    logic [IDX_W-1:0]      send_nxt;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  ram_we;
    logic                  ram_re;
    logic [HANDLE_W-1:0]   ram_rdata;

    ppss_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (SLOTS)
    ) u_handles (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_store),
        .i_wdata (r_job.handle),
        .i_re    (ram_re),
        .i_raddr (r_send),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || o_res.ready;
    assign send_nxt = ppss_next_idx(r_send);
    assign cnt_inc  = r_cnt + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_valid      = r_valid;
        n_send       = r_send;
        n_store      = r_store;
        n_cnt        = r_cnt;
        n_rd_slot    = r_rd_slot;
        n_rd_last    = r_rd_last;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_ev     = r_out_ev;
        n_out_handle = r_out_handle;
        n_out_slot   = r_out_slot;
        n_out_last   = r_out_last;
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_job;
                    n_cnt   = '0;
                    n_state = (i_q_job.kind == JOB_STORE) ? S_STORE : S_READ;
                end
            end
            S_STORE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_handle = r_job.handle;
                    n_out_slot   = ppss_slot_out(r_store);
                    n_out_last   = 1'b1;
                    if (r_valid[r_store]) begin
                        n_out_ev = EV_DROPPED;
                    end else begin
                        n_out_ev         = EV_STORED;
                        ram_we           = 1'b1;
                        n_valid[r_store] = 1'b1;
                        n_store          = ppss_next_idx(r_store);
                    end
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                if ((r_cnt != r_job.budget) && r_valid[r_send]) begin
                    ram_re          = 1'b1;
                    n_valid[r_send] = 1'b0;
                    n_send          = send_nxt;
                    n_cnt           = cnt_inc;
                    n_rd_slot       = r_send;
                    // A flush always ends with the new handle, so its drain is never last.
                    n_rd_last       = (r_job.kind != JOB_FLUSH) &&
                                      ((cnt_inc == r_job.budget) || !r_valid[send_nxt]);
                    n_state         = S_OUT;
                end else begin
                    n_state = (r_job.kind == JOB_FLUSH) ? S_PASS : S_IDLE;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_ev     = EV_SENT;
                    n_out_handle = ram_rdata;
                    n_out_slot   = ppss_slot_out(r_rd_slot);
                    n_out_last   = r_rd_last;
                    n_state      = r_rd_last ? S_IDLE : S_READ;
                end
            end
            S_PASS: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_ev     = EV_SENT;
                    n_out_handle = r_job.handle;
                    n_out_slot   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_send      <= '0;
            r_store     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_send      <= n_send;
            r_store     <= n_store;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_cnt        <= n_cnt;
        r_rd_slot    <= n_rd_slot;
        r_rd_last    <= n_rd_last;
        r_out_ev     <= n_out_ev;
        r_out_handle <= n_out_handle;
        r_out_slot   <= n_out_slot;
        r_out_last   <= n_out_last;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.event_res  = r_out_ev;
    assign o_res.handle_out = r_out_handle;
    assign o_res.slot_index = r_out_slot;
    assign o_res.last       = r_out_last;
endmodule
`default_nettype wire

### rtl/paced_packet_slot_shaper_unit.sv
// Top level of the paced packet slot shaper: front end, job queue and slot engine.
//
// Packet handles are kept in a ring of 32 slots. With pacing on, an enqueue stores its
// handle at the store index (or is dropped if that slot is taken) and each tick counts
// down the period; on expiry the rate mode releases a budget of slots, sent in ring order
// from the send index until the budget is spent or an empty slot is met. With pacing off,
// an enqueue flushes every queued slot and then sends its own handle; ticks do nothing.
// The front end takes one item per cycle as long as its four-entry job queue has room.
// Ticks that only count down push no job, but like every item they wait while the queue
// is full. The slot engine behind the queue handles a stored or dropped enqueue in its
// store state, and each sent slot in the read state, which starts the registered read of
// the handle memory, and then the output state. A drain job meeting an empty send slot
// ends in the read state; a flush job ends in the pass state that sends the new handle.
// The job in progress waits while the result receiver holds off a result.
// Configuration is written through a plain write port: index 0 is rate_mode, index 1
// is pacing_enable.
`default_nettype none
module paced_packet_slot_shaper_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ppss_cmd_if.sink                        i_cmd,
    ppss_res_if.source                      o_res
);
    import ppss_pkg::*;

    logic push;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    ppss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    ppss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head_job)
    );

    ppss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (head_job),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire

### rtl/ppss_checker.sv
// Port-level checker for the slot shaper, bound to the top level.
`default_nettype none
`include "paced_packet_slot_shaper_unit_macros.svh"
module ppss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_res_valid,
    input logic                            i_res_ready,
    input logic [1:0]                      i_res_event_res,
    input logic [ppss_pkg::HANDLE_W-1:0]   i_res_handle_out,
    input logic [ppss_pkg::SLOT_OUT_W-1:0] i_res_slot_index,
    input logic                            i_res_last
);
    import ppss_pkg::*;

    `PPSS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)
    `PPSS_ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable(i_res_event_res) && $stable(i_res_handle_out) && $stable(i_res_slot_index) && $stable(i_res_last))
    `PPSS_ASSERT_SAME(a_event_code, i_clk, i_rst_n, i_res_valid, (i_res_event_res == EV_STORED) || (i_res_event_res == EV_DROPPED) || (i_res_event_res == EV_SENT))
    // A store or a drop is the only result of its enqueue.
    `PPSS_ASSERT_SAME(a_store_last, i_clk, i_rst_n, i_res_valid && (i_res_event_res != EV_SENT), i_res_last)
endmodule

bind paced_packet_slot_shaper_unit ppss_checker u_ppss_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_event_res  (o_res.event_res),
    .i_res_handle_out (o_res.handle_out),
    .i_res_slot_index (o_res.slot_index),
    .i_res_last       (o_res.last)
);
`default_nettype wire
